### rtl/gaps_pkg.sv
package gaps_pkg;

    localparam int GRID_SIDE = 32;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int XY_W      = $clog2(GRID_SIDE);
    localparam int IDX_W     = $clog2(CELLS);
    localparam int SIZE_W    = XY_W + 1;
    localparam int G_W       = 11;
    localparam int F_W       = 12;
    localparam int AUX_W     = IDX_W + 1;

    localparam logic [G_W-1:0] COST_MAX  = '1;
    localparam logic [F_W-1:0] TOTAL_MAX = '1;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // aux memory word: obstacle bit on top, path cell below
    localparam logic [AUX_W-1:0] OBS_MASK  = {1'b1, {IDX_W{1'b0}}};
    localparam logic [AUX_W-1:0] PATH_MASK = {1'b0, {IDX_W{1'b1}}};

    typedef struct packed {
        logic [1:0]      req_type;
        logic [XY_W-1:0] cell_x;
        logic [XY_W-1:0] cell_y;
        logic            cell_blocked;
        logic [XY_W-1:0] goal_x;
        logic [XY_W-1:0] goal_y;
        logic [9:0]      step_index;
    } t_req;

    typedef struct packed {
        logic            found;
        logic [9:0]      path_length;
        logic [XY_W-1:0] step_x;
        logic [XY_W-1:0] step_y;
    } t_rsp;

    typedef struct packed {
        logic             is_open;
        logic             is_closed;
        logic [G_W-1:0]   g;
        logic [F_W-1:0]   f;
        logic [IDX_W-1:0] parent;
    } t_cell;

    localparam int CELL_W = $bits(t_cell);
    localparam t_cell CELL_RESET = '{1'b0, 1'b0, '0, TOTAL_MAX, '0};

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_SCAN,
        ST_PICK,
        ST_TRACE,
        ST_TRACE_W,
        ST_NB_RD,
        ST_NB_WR,
        ST_DONE
    } t_state;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (v > SIZE_W'(GRID_SIDE)) begin
            return SIZE_W'(GRID_SIDE);
        end
        return v;
    endfunction

    function automatic logic [1:0] dx_of(input logic [2:0] k);
        case (k)
            3'd0, 3'd4, 3'd5: return 2'b01;
            3'd1, 3'd6, 3'd7: return 2'b11;
            default:          return 2'b00;
        endcase
    endfunction

    function automatic logic [1:0] dy_of(input logic [2:0] k);
        case (k)
            3'd2, 3'd4, 3'd6: return 2'b01;
            3'd3, 3'd5, 3'd7: return 2'b11;
            default:          return 2'b00;
        endcase
    endfunction

endpackage

### rtl/gaps_ram.sv
module gaps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wmask,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int b = 0; b < WIDTH; b++) begin
                if (i_wmask[b]) begin
                    mem[i_addr][b] <= i_wdata[b];
                end
            end
        end
        o_rdata <= mem[i_addr];
    end

endmodule

### rtl/grid_astar_path_search.sv
// 8-connected A* search over a grid of up to 32 x 32 cells. Requests: load
// one cell, read one path step, run a search. A search clears the per-cell
// search memory, then, if the start lies inside the grid, for every
// expansion scans all 1024 cells for the open cell of lowest f, visits the
// eight neighbors and finally traces the path back; it runs until the goal
// is taken or no cell is open. After reset the block clears the obstacle
// map before it takes the first item. Configuration holds the grid size in
// use at 0x0 (width) and 0x4 (height); values outside 1..32 act as the
// nearest bound.
module grid_astar_path_search
    import gaps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_req        i_req,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    output t_rsp        o_rsp,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    t_state r_state, n_state;

    logic [SIZE_W-1:0] r_width, r_height;
    logic [SIZE_W-1:0] r_w, n_w, r_h, n_h;
    logic [IDX_W-1:0]  r_start, n_start, r_goal, n_goal;
    logic              r_start_in, n_start_in;
    logic [IDX_W:0]    r_cnt, n_cnt;
    logic              r_dv, n_dv;
    logic [IDX_W-1:0]  r_didx, n_didx;
    logic              r_any, n_any;
    logic [IDX_W-1:0]  r_best, n_best;
    t_cell             r_best_w, n_best_w;
    logic [2:0]        r_k, n_k;
    logic [IDX_W-1:0]  r_p, n_p, r_n, n_n, r_ni, n_ni;
    logic              r_found, n_found;
    logic [9:0]        r_len, n_len;
    logic              r_hit, n_hit;
    t_rsp              r_rsp, n_rsp;
    logic              r_rsp_valid, n_rsp_valid;

    logic              a_we;
    logic [IDX_W-1:0]  a_addr;
    t_cell             a_wdata, a_rdata;
    logic              b_we;
    logic [AUX_W-1:0]  b_mask, b_wdata, b_rdata;
    logic [IDX_W-1:0]  b_addr;

    logic              req_acc;
    logic              cfg_wr;
    logic [1:0]        dxk, dyk;
    logic [6:0]        nx_s, ny_s;
    logic              nb_in;
    logic [XY_W-1:0]   nb_x, nb_y, ddx, ddy;
    logic [10:0]       hd;
    logic [G_W-1:0]    g_new;
    logic [F_W:0]      f_sum;
    logic [F_W-1:0]    f_new;
    t_cell             upd;

    gaps_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_wmask ({CELL_W{1'b1}}),
        .i_addr  (a_addr),
        .i_wdata (a_wdata),
        .o_rdata (a_rdata)
    );

    gaps_ram #(.WIDTH(AUX_W), .DEPTH(CELLS)) u_aux_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_wmask (b_mask),
        .i_addr  (b_addr),
        .i_wdata (b_wdata),
        .o_rdata (b_rdata)
    );

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_prdata = i_paddr[2] ? {{(32-SIZE_W){1'b0}}, r_height}
                                 : {{(32-SIZE_W){1'b0}}, r_width};

    assign o_req_ready = (r_state == ST_IDLE) && (!r_rsp_valid || i_rsp_ready);
    assign req_acc     = o_req_ready && i_req_valid;
    assign o_rsp       = r_rsp;
    assign o_rsp_valid = r_rsp_valid;

    // neighbor of the cell under expansion
    assign dxk   = dx_of(r_k);
    assign dyk   = dy_of(r_k);
    assign nx_s  = {2'b00, r_best[XY_W-1:0]} + {{5{dxk[1]}}, dxk};
    assign ny_s  = {2'b00, r_best[IDX_W-1:XY_W]} + {{5{dyk[1]}}, dyk};
    assign nb_in = !nx_s[6] && !ny_s[6]
                && (nx_s[SIZE_W-1:0] < r_w) && (ny_s[SIZE_W-1:0] < r_h);

    // cost of the registered neighbor
    assign nb_x  = r_ni[XY_W-1:0];
    assign nb_y  = r_ni[IDX_W-1:XY_W];
    assign ddx   = (r_goal[XY_W-1:0] > nb_x) ? r_goal[XY_W-1:0] - nb_x
                                             : nb_x - r_goal[XY_W-1:0];
    assign ddy   = (r_goal[IDX_W-1:XY_W] > nb_y) ? r_goal[IDX_W-1:XY_W] - nb_y
                                                 : nb_y - r_goal[IDX_W-1:XY_W];
    assign hd    = ({6'b0, ddx} * {6'b0, ddx}) + ({6'b0, ddy} * {6'b0, ddy});
    assign g_new = (r_best_w.g == COST_MAX) ? COST_MAX : r_best_w.g + G_W'(1);
    assign f_sum = {2'b00, g_new} + {2'b00, hd};
    assign f_new = f_sum[F_W] ? TOTAL_MAX : f_sum[F_W-1:0];
    assign upd   = '{1'b1, 1'b0, g_new, f_new, r_best};

    always_comb begin
        n_state     = r_state;
        n_w         = r_w;
        n_h         = r_h;
        n_start     = r_start;
        n_goal      = r_goal;
        n_start_in  = r_start_in;
        n_cnt       = r_cnt;
        n_dv        = 1'b0;
        n_didx      = r_didx;
        n_any       = r_any;
        n_best      = r_best;
        n_best_w    = r_best_w;
        n_k         = r_k;
        n_p         = r_p;
        n_n         = r_n;
        n_ni        = r_ni;
        n_found     = r_found;
        n_len       = r_len;
        n_hit       = r_hit;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        a_we        = 1'b0;
        a_addr      = r_cnt[IDX_W-1:0];
        a_wdata     = CELL_RESET;
        b_we        = 1'b0;
        b_mask      = '0;
        b_addr      = r_cnt[IDX_W-1:0];
        b_wdata     = '0;

        case (r_state)
            ST_INIT: begin
                b_we   = 1'b1;
                b_mask = OBS_MASK;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt[IDX_W-1:0] == '1) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req_acc) begin
                    case (i_req.req_type)
                        REQ_LOAD: begin
                            b_we        = 1'b1;
                            b_mask      = OBS_MASK;
                            b_addr      = {i_req.cell_y, i_req.cell_x};
                            b_wdata     = {i_req.cell_blocked, {IDX_W{1'b0}}};
                            n_rsp_valid = 1'b1;
                            n_rsp       = '{r_found, r_len, '0, '0};
                        end
                        REQ_SEARCH: begin
                            n_w        = clamp_size(r_width);
                            n_h        = clamp_size(r_height);
                            n_start    = {i_req.cell_y, i_req.cell_x};
                            n_goal     = {i_req.goal_y, i_req.goal_x};
                            n_start_in = ({1'b0, i_req.cell_x} < clamp_size(r_width))
                                      && ({1'b0, i_req.cell_y} < clamp_size(r_height));
                            n_found    = 1'b0;
                            n_len      = '0;
                            n_cnt      = '0;
                            n_state    = ST_CLEAR;
                        end
                        REQ_READ: begin
                            b_addr  = i_req.step_index;
                            n_hit   = i_req.step_index < r_len;
                            n_state = ST_READ;
                        end
                        default: begin
                            n_rsp_valid = 1'b1;
                            n_rsp       = '{r_found, r_len, '0, '0};
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_rsp_valid = 1'b1;
                n_rsp       = '{r_found, r_len,
                                r_hit ? b_rdata[XY_W-1:0] : '0,
                                r_hit ? b_rdata[IDX_W-1:XY_W] : '0};
                n_state     = ST_IDLE;
            end
            ST_CLEAR: begin
                a_we            = 1'b1;
                a_wdata.is_open = r_start_in && (r_cnt[IDX_W-1:0] == r_start);
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt[IDX_W-1:0] == '1) begin
                    n_cnt   = '0;
                    n_any   = 1'b0;
                    n_state = r_start_in ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                // issue one read per cycle, compare its data in the next cycle
                if (!r_cnt[IDX_W]) begin
                    n_cnt  = r_cnt + 1'b1;
                    n_dv   = 1'b1;
                    n_didx = r_cnt[IDX_W-1:0];
                end
                if (r_dv && a_rdata.is_open && (!r_any || a_rdata.f < r_best_w.f)) begin
                    n_any    = 1'b1;
                    n_best   = r_didx;
                    n_best_w = a_rdata;
                end
                if (r_dv && r_didx == '1) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                if (!r_any) begin
                    n_state = ST_DONE;
                end else begin
                    a_we              = 1'b1;
                    a_addr            = r_best;
                    a_wdata           = r_best_w;
                    a_wdata.is_open   = 1'b0;
                    a_wdata.is_closed = 1'b1;
                    if (r_best == r_goal) begin
                        n_p     = r_best;
                        n_n     = '0;
                        n_state = ST_TRACE;
                    end else begin
                        n_k     = '0;
                        n_state = ST_NB_RD;
                    end
                end
            end
            ST_TRACE: begin
                if (r_p == r_start) begin
                    n_found = 1'b1;
                    n_len   = r_n;
                    n_state = ST_DONE;
                end else begin
                    b_we    = 1'b1;
                    b_mask  = PATH_MASK;
                    b_addr  = r_n;
                    b_wdata = {1'b0, r_p};
                    a_addr  = r_p;
                    n_n     = r_n + 1'b1;
                    n_state = ST_TRACE_W;
                end
            end
            ST_TRACE_W: begin
                n_p     = a_rdata.parent;
                n_state = ST_TRACE;
            end
            ST_NB_RD: begin
                if (nb_in) begin
                    n_ni    = {ny_s[XY_W-1:0], nx_s[XY_W-1:0]};
                    a_addr  = {ny_s[XY_W-1:0], nx_s[XY_W-1:0]};
                    b_addr  = {ny_s[XY_W-1:0], nx_s[XY_W-1:0]};
                    n_state = ST_NB_WR;
                end else if (r_k == 3'd7) begin
                    n_cnt   = '0;
                    n_any   = 1'b0;
                    n_state = ST_SCAN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_NB_WR: begin
                if (!b_rdata[IDX_W] && !a_rdata.is_closed && a_rdata.f > f_new) begin
                    a_we    = 1'b1;
                    a_addr  = r_ni;
                    a_wdata = upd;
                end
                if (r_k == 3'd7) begin
                    n_cnt   = '0;
                    n_any   = 1'b0;
                    n_state = ST_SCAN;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_NB_RD;
                end
            end
            ST_DONE: begin
                n_rsp_valid = 1'b1;
                n_rsp       = '{r_found, r_len, '0, '0};
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_width     <= SIZE_W'(GRID_SIDE);
            r_height    <= SIZE_W'(GRID_SIDE);
            r_cnt       <= '0;
            r_dv        <= 1'b0;
            r_any       <= 1'b0;
            r_found     <= 1'b0;
            r_len       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_dv        <= n_dv;
            r_any       <= n_any;
            r_found     <= n_found;
            r_len       <= n_len;
            r_rsp_valid <= n_rsp_valid;
            if (cfg_wr) begin
                if (i_paddr[2]) begin
                    r_height <= i_pwdata[SIZE_W-1:0];
                end else begin
                    r_width <= i_pwdata[SIZE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w        <= n_w;
        r_h        <= n_h;
        r_start    <= n_start;
        r_goal     <= n_goal;
        r_start_in <= n_start_in;
        r_didx     <= n_didx;
        r_best     <= n_best;
        r_best_w   <= n_best_w;
        r_k        <= n_k;
        r_p        <= n_p;
        r_n        <= n_n;
        r_ni       <= n_ni;
        r_hit      <= n_hit;
        r_rsp      <= n_rsp;
    end

    a_load_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.req_type == REQ_LOAD) |=> o_rsp_valid)
        else $error("load item gave no result in the next cycle");

    a_len_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_found |-> (r_len == '0))
        else $error("path length set without a found goal");

    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !a_we)
        else $error("cell memory written during open scan");

endmodule

### verif/tb.sv
module tb;
    import gaps_pkg::*;

    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;
    localparam logic [1:0] REQ_NONE    = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    t_req        i_req;
    logic        i_req_valid;
    logic        o_req_ready;
    t_rsp        o_rsp;
    logic        o_rsp_valid;
    logic        i_rsp_ready;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    grid_astar_path_search i_dut (.*);

    // path search shadow state
    bit          obst_map[CELLS];
    int unsigned cost_g[CELLS];
    int unsigned total_f[CELLS];
    int unsigned parent_idx[CELLS];
    bit          closed_set[CELLS];
    bit          open_set[CELLS];
    int unsigned path_cells[CELLS];
    int unsigned path_len;
    bit          last_found;
    logic [5:0]  width_reg;
    logic [5:0]  height_reg;

    t_rsp        rsp_queue[$];
    int          error_count;
    int          burst_left;
    bit          no_gaps;
    int          stall_pct;
    int          hold_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int unsigned clamp_dim(logic [5:0] v);
        if (v == 0) return 1;
        if (v > GRID_SIDE) return GRID_SIDE;
        return 32'(v);
    endfunction

    function automatic void search_path(int unsigned sx, int unsigned sy,
                                        int unsigned gx, int unsigned gy);
        int          dxs[8];
        int          dys[8];
        int unsigned w, h, start, goal, cur, nidx, g, f, ddx, ddy, p, n;
        int          nx, ny;
        bit          any;
        dxs = '{1, -1, 0, 0, 1, 1, -1, -1};
        dys = '{0, 0, 1, -1, 1, -1, 1, -1};
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        for (int i = 0; i < CELLS; i++) begin
            cost_g[i] = 0;
            total_f[i] = 4095;
            parent_idx[i] = 0;
            closed_set[i] = 0;
            open_set[i] = 0;
        end
        last_found = 0;
        path_len = 0;
        if (sx >= w || sy >= h) return;
        start = sy * GRID_SIDE + sx;
        goal = gy * GRID_SIDE + gx;
        open_set[start] = 1;
        forever begin
            any = 0;
            cur = 0;
            for (int i = 0; i < CELLS; i++) begin
                if (open_set[i] && (!any || total_f[i] < total_f[cur])) begin
                    cur = i;
                    any = 1;
                end
            end
            if (!any) return;
            open_set[cur] = 0;
            closed_set[cur] = 1;
            if (cur == goal) begin
                p = cur;
                n = 0;
                while (p != start && n < CELLS) begin
                    path_cells[n] = p;
                    n++;
                    p = parent_idx[p] % CELLS;
                end
                path_len = n;
                last_found = 1;
                return;
            end
            for (int k = 0; k < 8; k++) begin
                nx = int'(cur % GRID_SIDE) + dxs[k];
                ny = int'(cur / GRID_SIDE) + dys[k];
                if (nx < 0 || ny < 0 || nx >= int'(w) || ny >= int'(h)) continue;
                nidx = ny * GRID_SIDE + nx;
                if (obst_map[nidx] || closed_set[nidx]) continue;
                g = cost_g[cur] + 1;
                if (g > 2047) g = 2047;
                ddx = (gx > nx) ? gx - nx : nx - gx;
                ddy = (gy > ny) ? gy - ny : ny - gy;
                f = g + ddx * ddx + ddy * ddy;
                if (f > 4095) f = 4095;
                if (total_f[nidx] > f) begin
                    cost_g[nidx] = g;
                    total_f[nidx] = f;
                    parent_idx[nidx] = cur;
                    open_set[nidx] = 1;
                end
            end
        end
    endfunction

    function automatic t_rsp predict_rsp(t_req r);
        t_rsp        rsp;
        int unsigned c;
        rsp = '0;
        case (r.req_type)
            REQ_LOAD:   obst_map[r.cell_y * GRID_SIDE + r.cell_x] = r.cell_blocked;
            REQ_SEARCH: search_path(r.cell_x, r.cell_y, r.goal_x, r.goal_y);
            REQ_READ: begin
                if (r.step_index < path_len) begin
                    c = path_cells[r.step_index];
                    rsp.step_x = XY_W'(c % GRID_SIDE);
                    rsp.step_y = XY_W'(c / GRID_SIDE);
                end
            end
            default: ;
        endcase
        rsp.found = last_found;
        rsp.path_length = 10'(path_len);
        return rsp;
    endfunction

    task automatic send_item(t_req r);
        if (burst_left <= 0 && !no_gaps) begin
            i_req_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        i_req = r;
        i_req_valid = 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        rsp_queue.insert(rsp_queue.size(), predict_rsp(r));
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic send_fields(logic [1:0] kind, int x, int y, int blk,
                               int gx, int gy, int si);
        t_req r;
        r.req_type = kind;
        r.cell_x = x[XY_W-1:0];
        r.cell_y = y[XY_W-1:0];
        r.cell_blocked = blk[0];
        r.goal_x = gx[XY_W-1:0];
        r.goal_y = gy[XY_W-1:0];
        r.step_index = si[9:0];
        send_item(r);
    endtask

    task automatic drain;
        i_req_valid = 1'b0;
        while (rsp_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        i_psel = 1'b1;
        i_pwrite = 1'b1;
        i_penable = 1'b0;
        i_paddr = addr;
        i_pwdata = data;
        @(negedge i_clk);
        i_penable = 1'b1;
        @(negedge i_clk);
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        if (addr == ADDR_WIDTH) width_reg = data[5:0];
        else height_reg = data[5:0];
    endtask

    task automatic set_grid(int w, int h);
        drain();
        write_reg(ADDR_WIDTH, w);
        write_reg(ADDR_HEIGHT, h);
    endtask

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // receiver stall pattern plus long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_rsp_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (rsp_queue.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, o_rsp);
                error_count++;
            end else begin
                exp_rsp = rsp_queue[0];
                rsp_queue.delete(0);
                check_field("found", exp_rsp.found, o_rsp.found);
                check_field("path_length", exp_rsp.path_length, o_rsp.path_length);
                check_field("step_x", exp_rsp.step_x, o_rsp.step_x);
                check_field("step_y", exp_rsp.step_y, o_rsp.step_y);
            end
        end
    end

    task automatic test_directed;
        send_fields(REQ_READ, 0, 0, 0, 0, 0, 0);
        send_fields(REQ_NONE, 31, 31, 1, 31, 31, 1023);
        send_fields(REQ_SEARCH, 0, 0, 0, 31, 31, 0);
        send_fields(REQ_READ, 0, 0, 0, 0, 0, 0);
        send_fields(REQ_READ, 0, 0, 0, 0, 0, 30);
        send_fields(REQ_READ, 0, 0, 0, 0, 0, 31);
        send_fields(REQ_READ, 31, 31, 1, 31, 31, 1023);
        send_fields(REQ_LOAD, 31, 31, 1, 0, 0, 0);
        send_fields(REQ_SEARCH, 31, 31, 0, 31, 31, 0);
        send_fields(REQ_LOAD, 31, 31, 0, 0, 0, 0);
        // one column, height saturated to the full side
        set_grid(0, 63);
        send_fields(REQ_SEARCH, 0, 0, 0, 0, 31, 0);
        send_fields(REQ_READ, 0, 0, 0, 0, 0, 5);
        send_fields(REQ_SEARCH, 5, 0, 0, 0, 3, 0);
        send_fields(REQ_SEARCH, 0, 0, 0, 3, 3, 0);
        send_fields(REQ_LOAD, 0, 0, 1, 0, 0, 0);
        send_fields(REQ_SEARCH, 0, 0, 0, 0, 0, 0);
        send_fields(REQ_SEARCH, 0, 0, 0, 0, 4, 0);
        send_fields(REQ_LOAD, 0, 5, 1, 0, 0, 0);
        send_fields(REQ_SEARCH, 0, 1, 0, 0, 10, 0);
        send_fields(REQ_SEARCH, 0, 1, 0, 0, 5, 0);
        // one row
        set_grid(63, 0);
        send_fields(REQ_SEARCH, 31, 0, 0, 0, 0, 0);
        send_fields(REQ_READ, 0, 0, 0, 0, 0, 30);
        send_fields(REQ_LOAD, 0, 0, 0, 0, 0, 0);
        send_fields(REQ_LOAD, 0, 5, 0, 0, 0, 0);
        set_grid(32, 1);
    endtask

    task automatic test_backpressure;
        drain();
        no_gaps = 1;
        hold_cycles = 400;
        for (int i = 0; i < 30; i++)
            send_fields(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom_range(0, 40));
        no_gaps = 0;
    endtask

    task automatic test_random;
        int w, h, ws, hs;
        for (int round = 0; round < 36; round++) begin
            case (round % 4)
                0: stall_pct = 0;
                1: stall_pct = 30;
                2: stall_pct = 70;
                default: stall_pct = 10;
            endcase
            w = $urandom_range(1, 5);
            h = $urandom_range(1, 5);
            if ($urandom_range(0, 9) == 0) w = 0;
            if ($urandom_range(0, 9) == 0) h = 6;
            set_grid(w, h);
            ws = clamp_dim(6'(w));
            hs = clamp_dim(6'(h));
            for (int i = 0; i < 15; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_fields(REQ_LOAD, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom);
                else
                    send_fields(REQ_LOAD, $urandom_range(0, ws - 1), $urandom_range(0, hs - 1),
                                $urandom_range(0, 99) < 25, $urandom, $urandom, $urandom);
            end
            if ($urandom_range(0, 9) == 0)
                send_fields(REQ_SEARCH, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom);
            else
                send_fields(REQ_SEARCH, $urandom_range(0, ws - 1), $urandom_range(0, hs - 1),
                            $urandom, $urandom_range(0, ws - 1), $urandom_range(0, hs - 1),
                            $urandom);
            for (int i = 0; i < 12; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_fields(REQ_READ, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom);
                else
                    send_fields(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom_range(0, path_len + 1));
            end
            if ($urandom_range(0, 3) == 0)
                send_fields(REQ_NONE, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_req = '0;
        i_req_valid = 1'b0;
        i_rsp_ready = 1'b0;
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        i_paddr = '0;
        i_pwdata = '0;
        width_reg = 6'd32;
        height_reg = 6'd32;
        path_len = 0;
        last_found = 0;
        error_count = 0;
        burst_left = 0;
        no_gaps = 0;
        stall_pct = 20;
        hold_cycles = 0;
        foreach (obst_map[i]) obst_map[i] = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random();
        drain();
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && rsp_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #60000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
rtl/gaps_pkg.sv
rtl/gaps_ram.sv
rtl/grid_astar_path_search.sv
verif/tb.sv
